>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    localparam int USER_LAST_BIT = 0;
    localparam int USER_BAD_BIT  = 1;
    localparam int USER_W        = 2;

    typedef struct packed {
        logic       ok;
        logic       pad;
        logic [5:0] val;
    } sextet_t;

    // One queued decode job: up to three bytes, or a single error result
    typedef struct packed {
        logic [23:0] block;
        logic [1:0]  count;
        logic        eot;
        logic        bad;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic sextet_t classify(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] t;
        s = '0;
        t = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            t     = c - 8'h41;
            s.ok  = 1'b1;
            s.val = t[5:0];
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            t     = c - 8'h61 + 8'd26;
            s.ok  = 1'b1;
            s.val = t[5:0];
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            t     = c - 8'h30 + 8'd52;
            s.ok  = 1'b1;
            s.val = t[5:0];
        end
        else if (c == CHAR_PLUS)
        begin
            s.ok  = 1'b1;
            s.val = 6'd62;
        end
        else if (c == CHAR_SLASH)
        begin
            s.ok  = 1'b1;
            s.val = 6'd63;
        end
        else if (c == CHAR_PAD)
        begin
            s.ok  = 1'b1;
            s.pad = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks group position and posts decode jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // [7:0] symbol
    input  wire logic                    s_tlast,   // end_of_text
    input  wire b64d_pkg::queue_status_t q_status,
    output logic                         push,
    output b64d_pkg::job_t               push_job
);

    logic [17:0] store_reg, store_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_pad_reg, third_pad_next;

    b64d_pkg::sextet_t s;
    logic              accept;
    logic [5:0]        val;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign s        = b64d_pkg::classify(s_tdata);
    assign val      = s.pad ? 6'd0 : s.val;

    always_comb
    begin
        store_next     = store_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        push           = 1'b0;
        push_job       = '0;
        push_job.eot   = s_tlast;
        push_job.count = 2'd1;
        if (accept)
        begin
            if (!s.ok || (pos_reg != 2'd3 && s_tlast) ||
                (pos_reg == 2'd3 && third_pad_reg && !s.pad))
            begin
                // error: single result, group dropped
                push           = 1'b1;
                push_job.bad   = 1'b1;
                pos_next       = 2'd0;
                third_pad_next = 1'b0;
            end
            else if (pos_reg != 2'd3)
            begin
                store_next = {store_reg[11:0], val};
                pos_next   = pos_reg + 2'd1;
                if (pos_reg == 2'd2)
                    third_pad_next = s.pad;
            end
            else
            begin
                push           = 1'b1;
                push_job.block = {store_reg, val};
                if (s_tlast && third_pad_reg)
                    push_job.count = 2'd1;
                else if (s_tlast && s.pad)
                    push_job.count = 2'd2;
                else
                    push_job.count = 2'd3;
                pos_next       = 2'd0;
                third_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            third_pad_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
        end
    end

    // sextets are fully overwritten before a group completes
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short register FIFO of decode jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire b64d_pkg::job_t          push_job,
    input  wire logic                    pop,
    output b64d_pkg::job_t               head,
    output b64d_pkg::queue_status_t      status
);

    b64d_pkg::job_t                    mem_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == b64d_pkg::CNT_W'(b64d_pkg::QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? b64d_pkg::PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? b64d_pkg::PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Splits queued jobs into byte transactions behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire b64d_pkg::job_t              head,
    input  wire b64d_pkg::queue_status_t     q_status,
    output logic                             pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,   // message_end
    output logic [b64d_pkg::USER_W-1:0]      m_tuser    // [0] group_last, [1] bad_input
);

    logic [1:0] k_reg, k_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, mend_reg, bad_reg;

    logic load, issue, last;

    assign load  = !valid_reg || m_tready;
    assign issue = load && !q_status.empty;
    assign last  = (k_reg == head.count - 2'd1);
    assign pop   = issue && last;

    always_comb
    begin
        case (k_reg)
            2'd0:    byte_next = head.block[23:16];
            2'd1:    byte_next = head.block[15:8];
            default: byte_next = head.block[7:0];
        endcase
        valid_next = load ? !q_status.empty : valid_reg;
        k_next     = k_reg;
        if (issue)
            k_next = last ? 2'd0 : k_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            byte_reg <= byte_next;
            last_reg <= last;
            mend_reg <= last && head.eot;
            bad_reg  <= head.bad;
        end
    end

    assign m_tvalid                          = valid_reg;
    assign m_tdata                           = byte_reg;
    assign m_tlast                           = mend_reg;
    assign m_tuser[b64d_pkg::USER_LAST_BIT]  = last_reg;
    assign m_tuser[b64d_pkg::USER_BAD_BIT]   = bad_reg;

endmodule

`default_nettype wire

>>> rtl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 text decoder, one character in per cycle, bytes out in a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tdata carries one ASCII character, s_tlast marks the final
//   character of the message. Output stream: m_tdata carries a decoded byte,
//   m_tlast marks the last byte of the message, m_tuser[0] marks the last
//   result of one input character, m_tuser[1] flags an error (data then 0).
//   Every fourth character of a group yields three bytes (fewer for a padded
//   closing group); invalid characters, data after a third-place pad and a
//   message ending mid-group each yield one error transaction.
//   Path: the closing character's job is queued, then its bytes are registered.
//   Throughput: one character per cycle in, one byte per cycle
//   out; a four-deep job queue between the classifier and the byte sequencer
//   absorbs the three-byte bursts, so s_tready only drops when the output is
//   stalled long enough to fill that queue.
//   Reset clears the group position, the queue pointers and the output valid flag.
//   While m_tready is low the output transaction holds and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] symbol
    input  wire logic                        s_tlast,   // end_of_text
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,   // message_end
    output logic [b64d_pkg::USER_W-1:0]      m_tuser    // [0] group_last, [1] bad_input
);

    b64d_pkg::queue_status_t q_status;
    b64d_pkg::job_t          push_job;
    b64d_pkg::job_t          head;
    logic                    push;
    logic                    pop;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64d_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [7:0]                  s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [7:0]                  m_tdata,
    input  wire logic                        m_tlast,
    input  wire logic [b64d_pkg::USER_W-1:0] m_tuser
);

    logic out_bad;
    logic out_glast;
    logic in_seen;

    assign out_bad   = m_tuser[b64d_pkg::USER_BAD_BIT];
    assign out_glast = m_tuser[b64d_pkg::USER_LAST_BIT];
    assign in_seen   = s_tvalid && s_tready;

    // stalled output holds its transaction
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // an error transaction carries zero data and closes its character's results
    `ASSERT_IMPLIES(a_bad_zero, clk, rst_n, m_tvalid && out_bad, m_tdata == 8'h00 && out_glast)

    // end of message is always the last result of its character
    `ASSERT_IMPLIES(a_mend_glast, clk, rst_n, m_tvalid && m_tlast, out_glast)

    // an idle output stays idle unless in_seen or its $past value is set
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, !in_seen && !m_tvalid && $past(!in_seen),
        !m_tvalid)

endmodule

bind base64_stream_decoder_top b64d_checker u_checker (.*);

`default_nettype wire
